/* hdl/acr_pkg.sv */
// Package for the axis-angle rotation matrix block: payload types, fixed-point
// constants, the arctangent table and the shared Q30 helpers.
// No dependencies.
`timescale 1ns / 1ps
package acr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int RSQRT_STEPS       = 5;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0]        RSQRT_SEED  = 32'd2415919104;
  localparam logic [32:0]        THREE_Q30   = 33'd3221225472;
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } acr_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] col_0;
    logic signed [15:0] col_1;
    logic signed [15:0] col_2;
    logic               degenerate;
    logic               last_row;
  } acr_out_t;

  // Side data that travels with an item through the reciprocal square root.
  typedef struct packed {
    logic signed [15:0] angle;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
    logic [15:0]        mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic               degen;
    logic [4:0]         k;
  } acr_side_t;

  // Normalized axis, Q30.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
  } acr_vec_t;

  typedef logic signed [15:0] acr_q14_t;

  typedef struct packed {
    acr_q14_t [8:0] e;
    logic           degen;
  } acr_mat_t;

  function automatic logic signed [33:0] acr_mul30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    p = p >>> 30;
    return p[33:0];
  endfunction

  function automatic acr_q14_t acr_to_q14(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + 35'sd32768) >>> 16;
    if (t > 35'sd16384) t = 35'sd16384;
    if (t < -35'sd16384) t = -35'sd16384;
    return t[15:0];
  endfunction

endpackage

/* hdl/acr_rsqrt.sv */
// Pipelined axis normalization: sum of squares, shift search, five Newton
// steps of reciprocal square root and the scaled components. Uses acr_pkg.
`timescale 1ns / 1ps
module acr_rsqrt import acr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  acr_in_t            in_data,
  output logic               out_vld,
  output acr_vec_t           out_vec,
  output logic signed [15:0] out_angle
);

  localparam int NSTG = 3 * RSQRT_STEPS;

  // Stage 0: magnitudes and sum of squares.
  logic        s0_vld_r;
  acr_side_t   s0_side_r, s0_side_nxt;
  logic [31:0] s0_sum_r, s0_sum_nxt;

  always_comb begin
    s0_side_nxt       = '0;
    s0_side_nxt.angle = in_data.angle;
    s0_side_nxt.neg_x = in_data.axis_x[15];
    s0_side_nxt.neg_y = in_data.axis_y[15];
    s0_side_nxt.neg_z = in_data.axis_z[15];
    s0_side_nxt.mag_x = in_data.axis_x[15] ? 16'(-in_data.axis_x) : 16'(in_data.axis_x);
    s0_side_nxt.mag_y = in_data.axis_y[15] ? 16'(-in_data.axis_y) : 16'(in_data.axis_y);
    s0_side_nxt.mag_z = in_data.axis_z[15] ? 16'(-in_data.axis_z) : 16'(in_data.axis_z);
    s0_sum_nxt = 32'(s0_side_nxt.mag_x) * 32'(s0_side_nxt.mag_x)
               + 32'(s0_side_nxt.mag_y) * 32'(s0_side_nxt.mag_y)
               + 32'(s0_side_nxt.mag_z) * 32'(s0_side_nxt.mag_z);
    s0_side_nxt.degen = (s0_sum_nxt == '0);
  end

  // Stage 1: shift count so that the sum lands in [2^60, 2^62).
  logic        s1_vld_r;
  acr_side_t   s1_side_r, s1_side_nxt;
  logic [31:0] s1_sum_r;
  logic [4:0]  top_bit;

  always_comb begin
    top_bit = '0;
    for (int i = 0; i < 32; i++) begin
      if (s0_sum_r[i]) top_bit = 5'(i);
    end
    s1_side_nxt   = s0_side_r;
    s1_side_nxt.k = 5'((6'd61 - {1'b0, top_bit}) >> 1);
  end

  // Stage 2: normalized mantissa and Newton seed.
  logic [61:0] mm;
  logic [29:0] u_nxt;
  logic [32:0] five_u;

  always_comb begin
    mm     = {30'b0, s1_sum_r} << {s1_side_r.k, 1'b0};
    u_nxt  = mm[61:32];
    five_u = 33'(u_nxt) * 33'd5;
  end

  logic        nt_vld_r  [0:NSTG];
  acr_side_t   nt_side_r [0:NSTG];
  logic [29:0] nt_u_r    [0:NSTG];
  logic [31:0] nt_rr_r   [0:NSTG];
  logic [32:0] nt_aux_r  [0:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      nt_vld_r[0] <= 1'b0;
    end else begin
      s0_vld_r    <= in_vld;
      s1_vld_r    <= s0_vld_r;
      nt_vld_r[0] <= s1_vld_r;
    end
    s0_side_r    <= s0_side_nxt;
    s0_sum_r     <= s0_sum_nxt;
    s1_side_r    <= s1_side_nxt;
    s1_sum_r     <= s0_sum_r;
    nt_side_r[0] <= s1_side_r;
    nt_u_r[0]    <= u_nxt;
    nt_rr_r[0]   <= RSQRT_SEED - 32'(five_u >> 2);
    nt_aux_r[0]  <= '0;
  end

  // Each Newton step takes three stages: r*r, u*q, then r*(3 - p).
  for (genvar p = 0; p < NSTG; p++) begin : g_newton
    logic [63:0] prod;
    logic [32:0] aux_nxt;
    logic [31:0] rr_nxt;
    logic [31:0] t_val;

    always_comb begin
      prod    = '0;
      t_val   = '0;
      aux_nxt = nt_aux_r[p];
      rr_nxt  = nt_rr_r[p];
      unique case (p % 3)
        0: begin
          prod    = 64'(nt_rr_r[p]) * 64'(nt_rr_r[p]);
          aux_nxt = prod[62:30];
        end
        1: begin
          prod    = 64'(nt_u_r[p]) * 64'(nt_aux_r[p]);
          aux_nxt = prod[62:30];
        end
        default: begin
          t_val  = (nt_aux_r[p] > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - nt_aux_r[p]);
          prod   = 64'(nt_rr_r[p]) * 64'(t_val);
          rr_nxt = prod[62:31];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nt_vld_r[p+1] <= 1'b0;
      end else begin
        nt_vld_r[p+1] <= nt_vld_r[p];
      end
      nt_side_r[p+1] <= nt_side_r[p];
      nt_u_r[p+1]    <= nt_u_r[p];
      nt_aux_r[p+1]  <= aux_nxt;
      nt_rr_r[p+1]   <= rr_nxt;
    end
  end

  // Component scaling, then sign restore.
  logic        c1_vld_r;
  acr_side_t   c1_side_r;
  logic [31:0] c1_x_r, c1_y_r, c1_z_r;
  logic [62:0] px, py, pz;
  logic [30:0] kx, ky, kz;
  acr_side_t   sd;

  always_comb begin
    sd = nt_side_r[NSTG];
    kx = 31'({15'b0, sd.mag_x} << sd.k);
    ky = 31'({15'b0, sd.mag_y} << sd.k);
    kz = 31'({15'b0, sd.mag_z} << sd.k);
    px = 63'(kx) * 63'(nt_rr_r[NSTG]);
    py = 63'(ky) * 63'(nt_rr_r[NSTG]);
    pz = 63'(kz) * 63'(nt_rr_r[NSTG]);
  end

  logic     c2_vld_r;
  acr_vec_t c2_vec_r;
  logic signed [15:0] c2_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= nt_vld_r[NSTG];
      c2_vld_r <= c1_vld_r;
    end
    c1_side_r      <= sd;
    c1_x_r         <= px[62:31];
    c1_y_r         <= py[62:31];
    c1_z_r         <= pz[62:31];
    c2_vec_r.x     <= c1_side_r.neg_x ? -$signed(c1_x_r) : $signed(c1_x_r);
    c2_vec_r.y     <= c1_side_r.neg_y ? -$signed(c1_y_r) : $signed(c1_y_r);
    c2_vec_r.z     <= c1_side_r.neg_z ? -$signed(c1_z_r) : $signed(c1_z_r);
    c2_vec_r.degen <= c1_side_r.degen;
    c2_angle_r     <= c1_side_r.angle;
  end

  assign out_vld   = c2_vld_r;
  assign out_vec   = c2_vec_r;
  assign out_angle = c2_angle_r;

endmodule

/* hdl/acr_cordic.sv */
// Pipelined sine and cosine: two range-reduction stages and one register
// stage per CORDIC iteration. Uses acr_pkg; carries the normalized axis along.
`timescale 1ns / 1ps
module acr_cordic import acr_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_angle,
  input  acr_vec_t           in_vec,
  output logic               out_vld,
  output acr_vec_t           out_vec,
  output logic signed [32:0] out_sin,
  output logic signed [32:0] out_cos
);

  localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

  logic               r1_vld_r;
  logic signed [34:0] r1_z_r, z_full, r1_z_nxt;
  acr_vec_t           r1_vec_r;

  always_comb begin
    z_full   = 35'(in_angle) <<< 18;
    r1_z_nxt = z_full;
    if (z_full > PI_Q30) r1_z_nxt = z_full - TWO_PI_Q30;
    else if (z_full < -PI_Q30) r1_z_nxt = z_full + TWO_PI_Q30;
  end

  logic               cd_vld_r  [0:N];
  logic signed [32:0] cd_x_r    [0:N];
  logic signed [32:0] cd_y_r    [0:N];
  logic signed [34:0] cd_z_r    [0:N];
  logic               cd_flip_r [0:N];
  acr_vec_t           cd_vec_r  [0:N];
  logic signed [34:0] f_z_nxt;
  logic               f_flip_nxt;

  // Fold into [-pi/2, pi/2]; a fold by pi negates both results at the end.
  always_comb begin
    f_z_nxt    = r1_z_r;
    f_flip_nxt = 1'b0;
    if (r1_z_r > HALF_PI_Q30) begin
      f_z_nxt    = r1_z_r - PI_Q30;
      f_flip_nxt = 1'b1;
    end else if (r1_z_r < -HALF_PI_Q30) begin
      f_z_nxt    = r1_z_r + PI_Q30;
      f_flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r    <= 1'b0;
      cd_vld_r[0] <= 1'b0;
    end else begin
      r1_vld_r    <= in_vld;
      cd_vld_r[0] <= r1_vld_r;
    end
    r1_z_r       <= r1_z_nxt;
    r1_vec_r     <= in_vec;
    cd_x_r[0]    <= GAIN_Q30;
    cd_y_r[0]    <= '0;
    cd_z_r[0]    <= f_z_nxt;
    cd_flip_r[0] <= f_flip_nxt;
    cd_vec_r[0]  <= r1_vec_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [32:0] dx, dy;
    logic signed [34:0] at;

    always_comb begin
      dx = cd_y_r[i] >>> i;
      dy = cd_x_r[i] >>> i;
      at = $signed({5'b0, ATAN_Q30[i]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_vld_r[i+1] <= 1'b0;
      end else begin
        cd_vld_r[i+1] <= cd_vld_r[i];
      end
      if (!cd_z_r[i][34]) begin
        cd_x_r[i+1] <= cd_x_r[i] - dx;
        cd_y_r[i+1] <= cd_y_r[i] + dy;
        cd_z_r[i+1] <= cd_z_r[i] - at;
      end else begin
        cd_x_r[i+1] <= cd_x_r[i] + dx;
        cd_y_r[i+1] <= cd_y_r[i] - dy;
        cd_z_r[i+1] <= cd_z_r[i] + at;
      end
      cd_flip_r[i+1] <= cd_flip_r[i];
      cd_vec_r[i+1]  <= cd_vec_r[i];
    end
  end

  logic               o_vld_r;
  logic signed [32:0] o_sin_r, o_cos_r;
  acr_vec_t           o_vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= cd_vld_r[N];
    end
    o_sin_r <= cd_flip_r[N] ? -cd_y_r[N] : cd_y_r[N];
    o_cos_r <= cd_flip_r[N] ? -cd_x_r[N] : cd_x_r[N];
    o_vec_r <= cd_vec_r[N];
  end

  assign out_vld = o_vld_r;
  assign out_vec = o_vec_r;
  assign out_sin = o_sin_r;
  assign out_cos = o_cos_r;

endmodule

/* hdl/acr_matrix.sv */
// Rodrigues matrix assembly in four register stages: products, products with
// (1 - cos), element sums, rounding to Q1.14. Uses acr_pkg.
`timescale 1ns / 1ps
module acr_matrix import acr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  acr_vec_t           in_vec,
  input  logic signed [32:0] in_sin,
  input  logic signed [32:0] in_cos,
  output logic               out_vld,
  output acr_mat_t           out_mat
);

  logic signed [33:0] x, y, z, sn, cs;

  always_comb begin
    x  = 34'(in_vec.x);
    y  = 34'(in_vec.y);
    z  = 34'(in_vec.z);
    sn = 34'(in_sin);
    cs = 34'(in_cos);
  end

  logic               m1_vld_r, m2_vld_r, m3_vld_r, m4_vld_r;
  logic               m1_dg_r, m2_dg_r, m3_dg_r;
  logic signed [33:0] m1_omc_r, m1_cs_r, m1_xx_r, m1_yy_r, m1_zz_r, m1_xy_r, m1_xz_r, m1_yz_r;
  logic signed [33:0] m1_zs_r, m1_ys_r, m1_xs_r;
  logic signed [33:0] m2_cs_r, m2_xx_r, m2_yy_r, m2_zz_r, m2_xy_r, m2_xz_r, m2_yz_r;
  logic signed [33:0] m2_zs_r, m2_ys_r, m2_xs_r;
  logic signed [34:0] m3_e_r [9];
  acr_mat_t           m4_mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= in_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
    end
    m1_dg_r  <= in_vec.degen;
    m1_omc_r <= ONE_Q30 - cs;
    m1_cs_r  <= cs;
    m1_xx_r  <= acr_mul30(x, x);
    m1_yy_r  <= acr_mul30(y, y);
    m1_zz_r  <= acr_mul30(z, z);
    m1_xy_r  <= acr_mul30(x, y);
    m1_xz_r  <= acr_mul30(x, z);
    m1_yz_r  <= acr_mul30(y, z);
    m1_zs_r  <= acr_mul30(z, sn);
    m1_ys_r  <= acr_mul30(y, sn);
    m1_xs_r  <= acr_mul30(x, sn);

    m2_dg_r  <= m1_dg_r;
    m2_cs_r  <= m1_cs_r;
    m2_xx_r  <= acr_mul30(m1_xx_r, m1_omc_r);
    m2_yy_r  <= acr_mul30(m1_yy_r, m1_omc_r);
    m2_zz_r  <= acr_mul30(m1_zz_r, m1_omc_r);
    m2_xy_r  <= acr_mul30(m1_xy_r, m1_omc_r);
    m2_xz_r  <= acr_mul30(m1_xz_r, m1_omc_r);
    m2_yz_r  <= acr_mul30(m1_yz_r, m1_omc_r);
    m2_zs_r  <= m1_zs_r;
    m2_ys_r  <= m1_ys_r;
    m2_xs_r  <= m1_xs_r;

    m3_dg_r   <= m2_dg_r;
    m3_e_r[0] <= 35'(m2_cs_r) + 35'(m2_xx_r);
    m3_e_r[1] <= 35'(m2_xy_r) - 35'(m2_zs_r);
    m3_e_r[2] <= 35'(m2_xz_r) + 35'(m2_ys_r);
    m3_e_r[3] <= 35'(m2_xy_r) + 35'(m2_zs_r);
    m3_e_r[4] <= 35'(m2_cs_r) + 35'(m2_yy_r);
    m3_e_r[5] <= 35'(m2_yz_r) - 35'(m2_xs_r);
    m3_e_r[6] <= 35'(m2_xz_r) - 35'(m2_ys_r);
    m3_e_r[7] <= 35'(m2_yz_r) + 35'(m2_xs_r);
    m3_e_r[8] <= 35'(m2_cs_r) + 35'(m2_zz_r);

    // A zero axis gives the identity whatever the arithmetic produced.
    m4_mat_r.degen <= m3_dg_r;
    for (int i = 0; i < 9; i++) begin
      if (m3_dg_r) m4_mat_r.e[i] <= (i % 4 == 0) ? Q14_ONE : '0;
      else m4_mat_r.e[i] <= acr_to_q14(m3_e_r[i]);
    end
  end

  assign out_vld = m4_vld_r;
  assign out_mat = m4_mat_r;

endmodule

/* hdl/axis_angle_rotation_matrix.sv */
// Top level of the axis-angle rotation matrix block: input pacing, the
// processing pipeline and the row sequencer. Uses acr_pkg and the acr_ modules.
//
// Usage: drive in_data and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. busy then goes high, so
// transactions are paced to the single result channel, which carries three
// rows per transaction. Each transaction yields three results on consecutive
// cycles, rows 0, 1 and 2, each shown for one cycle with out_valid high;
// last_row marks row 2 and degenerate marks a zero axis (identity rows).
// From the accepting edge to row 0 an item passes three setup stages, fifteen
// Newton stages and two component stages, two reduction stages, one stage per
// CORDIC iteration and one flip stage, four matrix stages and the output
// register.
// The receiver cannot stall: results are presented once and never held.
// A synchronous reset clears all valid bits and the pacing counter; items in
// flight are dropped.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix import acr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  acr_in_t  in_data,
  output logic     out_valid,
  output acr_out_t out_data
);

  logic [1:0] pace_r, pace_nxt;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (pace_r != 2'd0);

  always_comb begin
    pace_nxt = pace_r;
    if (accept) pace_nxt = 2'd2;
    else if (pace_r != 2'd0) pace_nxt = pace_r - 2'd1;
  end

  logic               rs_vld;
  acr_vec_t           rs_vec;
  logic signed [15:0] rs_angle;

  acr_rsqrt u_rsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .in_data   (in_data),
    .out_vld   (rs_vld),
    .out_vec   (rs_vec),
    .out_angle (rs_angle)
  );

  logic               cd_vld;
  acr_vec_t           cd_vec;
  logic signed [32:0] cd_sin, cd_cos;

  acr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rs_vld),
    .in_angle (rs_angle),
    .in_vec   (rs_vec),
    .out_vld  (cd_vld),
    .out_vec  (cd_vec),
    .out_sin  (cd_sin),
    .out_cos  (cd_cos)
  );

  logic     mx_vld;
  acr_mat_t mx_mat;

  acr_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (cd_vld),
    .in_vec  (cd_vec),
    .in_sin  (cd_sin),
    .in_cos  (cd_cos),
    .out_vld (mx_vld),
    .out_mat (mx_mat)
  );

  // Row sequencer: row 0 goes out straight from the matrix, rows 1 and 2
  // from the held copy. Input pacing holds the next matrix until both are out.
  acr_mat_t   hold_r, hold_nxt;
  logic [1:0] row_r, row_nxt;
  logic       ov_r, ov_nxt;
  acr_out_t   od_r, od_nxt;
  acr_mat_t   src;
  logic [1:0] sel;

  always_comb begin
    hold_nxt = hold_r;
    row_nxt  = row_r;
    ov_nxt   = 1'b0;
    src      = hold_r;
    sel      = row_r;
    if (mx_vld) begin
      hold_nxt = mx_mat;
      src      = mx_mat;
      sel      = 2'd0;
      row_nxt  = 2'd1;
      ov_nxt   = 1'b1;
    end else if (row_r != 2'd0) begin
      row_nxt = (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
      ov_nxt  = 1'b1;
    end
    od_nxt.row_index  = sel;
    od_nxt.degenerate = src.degen;
    od_nxt.last_row   = (sel == 2'd2);
    unique case (sel)
      2'd0: begin
        od_nxt.col_0 = src.e[0];
        od_nxt.col_1 = src.e[1];
        od_nxt.col_2 = src.e[2];
      end
      2'd1: begin
        od_nxt.col_0 = src.e[3];
        od_nxt.col_1 = src.e[4];
        od_nxt.col_2 = src.e[5];
      end
      default: begin
        od_nxt.col_0 = src.e[6];
        od_nxt.col_1 = src.e[7];
        od_nxt.col_2 = src.e[8];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pace_r <= 2'd0;
      row_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      pace_r <= pace_nxt;
      row_r  <= row_nxt;
      ov_r   <= ov_nxt;
    end
    hold_r <= hold_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy ##1 !busy) else $error("pacing counter slip");
  a_row0_then_row1 : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_index == 2'd0) |=> (out_valid && out_data.row_index == 2'd1))
    else $error("row 1 missing");
  a_row1_then_row2 : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_index == 2'd1) |=> (out_valid && out_data.row_index == 2'd2))
    else $error("row 2 missing");
  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    mx_vld |-> (row_r == 2'd0)) else $error("matrix arrived during row output");
  a_last_marks_row2 : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (out_data.row_index == 2'd2)))
    else $error("last_row mismatch");

endmodule

/* verif/axis_angle_rotation_matrix_tb.sv */
// Self-checking testbench for axis_angle_rotation_matrix: drives angle/axis
// transactions and checks every matrix row against a Rodrigues-form predictor.
// Depends on acr_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
  import acr_pkg::*;

  localparam int STAGES     = CORDIC_STAGES_DEF;
  localparam int LATENCY    = 3 * 5 + STAGES + 15;
  localparam int IDLE_LIMIT = 2000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  acr_in_t  in_data;
  logic     out_valid;
  acr_out_t out_data;

  acr_out_t row_queue[$];
  int       mismatches;
  int       idle_cycles;
  int       sender_idle_pct;

  axis_angle_rotation_matrix #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(input longint a, input int s);
    return a >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return floor_shift(a * b, 30);
  endfunction

  function automatic logic signed [15:0] q30_to_q14(input longint v);
    longint q;
    q = floor_shift(v + 32768, 16);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic longint unit_comp(input longint a, input int k,
                                       input longint unsigned r);
    longint unsigned mag;
    longint v;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    v = longint'(((mag << k) * r) >> 31);
    return (a < 0) ? -v : v;
  endfunction

  // Works out the three rows that one transaction yields.
  task automatic predict_rows(input acr_in_t it);
    longint ax, ay, az, x, y, z, zr, cx, cy, dx, dy, sn, cs, omc, xy, xz, yz;
    longint unsigned s2, mm, u, r, q, p, t;
    longint m[9];
    int k;
    bit degen, flip;
    acr_out_t row;
    ax = it.axis_x;
    ay = it.axis_y;
    az = it.axis_z;
    s2 = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
    degen = (s2 == 0);
    if (degen) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? longint'(ONE_Q30) : 0;
    end else begin
      mm = s2;
      k = 0;
      while (mm < (64'd1 << 60) && k < 31) begin
        mm = mm << 2;
        k++;
      end
      u = mm >> 32;
      r = 64'd2415919104 - ((5 * u) >> 2);
      for (int i = 0; i < RSQRT_STEPS; i++) begin
        q = (r * r) >> 30;
        p = (u * q) >> 30;
        t = (p > 64'd3221225472) ? 64'd0 : 64'd3221225472 - p;
        r = (r * t) >> 31;
      end
      x = unit_comp(ax, k, r);
      y = unit_comp(ay, k, r);
      z = unit_comp(az, k, r);
      // Range reduction to [-pi/2, pi/2], then the CORDIC rotation.
      zr = longint'(it.angle) * 262144;
      flip = 1'b0;
      if (zr > longint'(PI_Q30)) zr -= longint'(TWO_PI_Q30);
      else if (zr < -longint'(PI_Q30)) zr += longint'(TWO_PI_Q30);
      if (zr > longint'(HALF_PI_Q30)) begin
        zr -= longint'(PI_Q30);
        flip = 1'b1;
      end else if (zr < -longint'(HALF_PI_Q30)) begin
        zr += longint'(PI_Q30);
        flip = 1'b1;
      end
      cx = longint'(GAIN_Q30);
      cy = 0;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
        dx = floor_shift(cy, i);
        dy = floor_shift(cx, i);
        if (zr >= 0) begin
          cx -= dx; cy += dy; zr -= longint'(ATAN_Q30[i]);
        end else begin
          cx += dx; cy -= dy; zr += longint'(ATAN_Q30[i]);
        end
      end
      cs = flip ? -cx : cx;
      sn = flip ? -cy : cy;
      omc = longint'(ONE_Q30) - cs;
      xy = qmul(qmul(x, y), omc);
      xz = qmul(qmul(x, z), omc);
      yz = qmul(qmul(y, z), omc);
      m[0] = cs + qmul(qmul(x, x), omc);
      m[1] = xy - qmul(z, sn);
      m[2] = xz + qmul(y, sn);
      m[3] = xy + qmul(z, sn);
      m[4] = cs + qmul(qmul(y, y), omc);
      m[5] = yz - qmul(x, sn);
      m[6] = xz - qmul(y, sn);
      m[7] = yz + qmul(x, sn);
      m[8] = cs + qmul(qmul(z, z), omc);
    end
    for (int i = 0; i < 3; i++) begin
      row.row_index  = 2'(i);
      row.col_0      = q30_to_q14(m[3 * i]);
      row.col_1      = q30_to_q14(m[3 * i + 1]);
      row.col_2      = q30_to_q14(m[3 * i + 2]);
      row.degenerate = degen;
      row.last_row   = (i == 2);
      row_queue.push_back(row);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_rotation(input acr_in_t it);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_data = it;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_rows(it);
  endtask

  task automatic wait_rows_drained();
    @(negedge clk);
    start = 1'b0;
    while (row_queue.size() != 0) @(posedge clk);
  endtask

  function automatic acr_in_t make_item(input int a, input int x, input int y,
                                        input int z);
    acr_in_t it;
    it.angle  = 16'(a);
    it.axis_x = 16'(x);
    it.axis_y = 16'(y);
    it.axis_z = 16'(z);
    return it;
  endfunction

  function automatic logic [15:0] random_component();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($urandom_range(7)) - 16'd3;
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      3: return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_directed();
    sender_idle_pct = 0;
    send_rotation(make_item(0, 0, 0, 0));
    send_rotation(make_item(12868, 0, 0, 0));
    send_rotation(make_item(0, 16384, 0, 0));
    send_rotation(make_item(6434, 0, 0, 1));
    send_rotation(make_item(-6434, 0, 1, 0));
    send_rotation(make_item(12867, 1, 1, 1));
    send_rotation(make_item(12868, 1, 1, 1));
    send_rotation(make_item(-12868, -1, 2, 3));
    send_rotation(make_item(6433, 100, -200, 300));
    send_rotation(make_item(6435, 100, -200, 300));
    send_rotation(make_item(-6435, 5, 5, 0));
    send_rotation(make_item(25736, 7, 0, -7));
    send_rotation(make_item(32767, 32767, 32767, 32767));
    send_rotation(make_item(-32768, -32768, -32768, -32768));
    send_rotation(make_item(32767, -32768, 32767, 0));
    send_rotation(make_item(-32768, 0, 0, -32768));
    send_rotation(make_item(-1, 1, 0, 0));
    send_rotation(make_item(1, 0, -1, 0));
    send_rotation(make_item(3217, 21845, 21845, 21845));
    send_rotation(make_item(-19302, 3, -4, 12));
    // Hold off until the pipeline has delivered everything in flight.
    wait_rows_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    acr_in_t it;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      it.angle  = 16'($urandom_range(65535));
      it.axis_x = random_component();
      it.axis_y = random_component();
      it.axis_z = random_component();
      send_rotation(it);
    end
  endtask

  always @(posedge clk) begin
    acr_out_t want;
    if (rst_n && out_valid) begin
      if (row_queue.size() == 0) begin
        report_mismatch("row with no transaction outstanding");
      end else begin
        want = row_queue.pop_front();
        if (out_data.row_index !== want.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d",
                                    out_data.row_index, want.row_index));
        if (out_data.col_0 !== want.col_0)
          report_mismatch($sformatf("row %0d col_0 %0d, want %0d",
                                    want.row_index, out_data.col_0, want.col_0));
        if (out_data.col_1 !== want.col_1)
          report_mismatch($sformatf("row %0d col_1 %0d, want %0d",
                                    want.row_index, out_data.col_1, want.col_1));
        if (out_data.col_2 !== want.col_2)
          report_mismatch($sformatf("row %0d col_2 %0d, want %0d",
                                    want.row_index, out_data.col_2, want.col_2));
        if (out_data.degenerate !== want.degenerate)
          report_mismatch($sformatf("row %0d degenerate %b, want %b",
                                    want.row_index, out_data.degenerate,
                                    want.degenerate));
        if (out_data.last_row !== want.last_row)
          report_mismatch($sformatf("row %0d last_row %b, want %b",
                                    want.row_index, out_data.last_row,
                                    want.last_row));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches      = 0;
    idle_cycles     = 0;
    sender_idle_pct = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150, 18);
    test_random(150, 46);
    test_random(140, 0);
    wait_rows_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && row_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
